### hw/rtl/gfs_pkg.sv
// ----------------------------------------------------------------------------
// gfs_pkg
// Shared types and constants for the gravity field force sum block.
// ----------------------------------------------------------------------------
package gfs_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int MASK_BITS   = 16;
    localparam int SLOT_W      = $clog2(MAX_SOURCES);

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // one source table entry
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] strength;
        logic               spherical;
        logic [MASK_BITS-1:0] mask;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SQ,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/gfs_table.sv
// ----------------------------------------------------------------------------
// gfs_table
// Source table: one synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gfs_table (
    input  logic                         clk,
    input  logic                         we,
    input  logic [gfs_pkg::SLOT_W-1:0]   waddr,
    input  gfs_pkg::entry_t              wdata,
    input  logic [gfs_pkg::SLOT_W-1:0]   raddr,
    output gfs_pkg::entry_t              rdata
);
    import gfs_pkg::*;

    entry_t mem [MAX_SOURCES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/gfs_divider.sv
// ----------------------------------------------------------------------------
// gfs_divider
// Restoring divider, 64 by 34 bits unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfs_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [33:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import gfs_pkg::*;

    logic [63:0] quo_reg;
    logic [34:0] rem_reg;
    logic [33:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [34:0] shifted;
    logic [35:0] diff;

    assign shifted  = {rem_reg[33:0], quo_reg[63]};
    assign diff     = {1'b0, shifted} - {2'b00, den_reg};
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd64;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            if (!diff[35])
            begin
                rem_reg <= diff[34:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

endmodule

### hw/rtl/gravity_field_force_sum.sv
// ----------------------------------------------------------------------------
// gravity_field_force_sum
// Sums point and uniform gravity sources from a 16-entry table, Q16.16.
// ----------------------------------------------------------------------------
// channel  | handshake            | ports
// command  | start & !busy        | operation slot vec_x/y/z strength
//          |                      | spherical select_mask
// result   | done strobe, 1 cycle | force_x/y/z saturated
//
// Write and remove leave busy low. A query walks all 16 slots: a skipped or
// uniform slot takes the read, check and accumulate states; a spherical slot
// adds the square and a 34-step square root, then, unless at zero distance,
// three divides, one per axis, on one shared divider.
// The result strobe comes in the first cycle with busy low again.
// Reset clears the valid bits at once; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module gravity_field_force_sum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [3:0]          slot,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    input  logic signed [31:0]  strength,
    input  logic                spherical,
    input  logic [15:0]         select_mask,
    output logic                done,
    output logic signed [31:0]  force_x,
    output logic signed [31:0]  force_y,
    output logic signed [31:0]  force_z,
    output logic                saturated
);
    import gfs_pkg::*;

    state_t state_reg, state_next;
    logic [MAX_SOURCES-1:0] valid_reg;
    logic [SLOT_W:0]  idx_reg, idx_next;
    logic [1:0]       axis_reg, axis_next;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [MASK_BITS-1:0] qmask_reg;
    entry_t           ent;
    logic signed [32:0] d_reg [3];
    logic [65:0]      sq_reg;
    logic [33:0]      root_reg;
    logic [5:0]       bit_reg;
    logic [63:0]      prod;
    logic signed [37:0] acc_reg [3];
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic             sat_reg, done_reg;

    logic             accept, wr_en, div_start, div_done;
    logic [63:0]      div_q;
    entry_t           wr_data;
    logic [SLOT_W-1:0] raddr;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign wr_en  = accept && (op_t'(operation) == OP_WRITE);
    assign wr_data = '{vx: vec_x, vy: vec_y, vz: vec_z, strength: strength,
                       spherical: spherical, mask: select_mask[MASK_BITS-1:0]};
    assign raddr  = idx_reg[SLOT_W-1:0];

    gfs_table u_table (
        .clk(clk), .we(wr_en), .waddr(slot[SLOT_W-1:0]), .wdata(wr_data),
        .raddr(raddr), .rdata(ent)
    );

    // divider latches the product in the same cycle it is started
    gfs_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod),
        .divisor(root_reg), .done(div_done), .quotient(div_q)
    );

    // square root trial, magnitudes
    logic [33:0] trial;
    logic [67:0] trial_sq;
    logic [32:0] mag_d [3];
    logic [32:0] mag_s;
    logic [32:0] mag_da;
    logic        neg_term;
    logic signed [32:0] da;

    assign trial    = root_reg | (34'd1 << bit_reg);
    assign trial_sq = trial * trial;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_d[i] = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
        end
    end
    assign da       = d_reg[axis_reg];
    assign mag_da   = mag_d[axis_reg];
    assign mag_s    = ent.strength[31] ? 33'(-{ent.strength[31], ent.strength})
                                       : {1'b0, ent.strength};
    assign neg_term = (ent.strength[31] != da[32]) && (da != '0);
    assign prod     = 64'(mag_s[31:0]) * 64'(mag_da[31:0])
                    + (mag_da[32] ? {mag_s[31:0], 32'd0} : 64'd0)
                    + (mag_s[32] ? {mag_da[31:0], 32'd0} : 64'd0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        axis_next  = axis_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept && op_t'(operation) == OP_QUERY)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!valid_reg[raddr] || (ent.mask & qmask_reg) == '0
                    || ent.strength == '0 || !ent.spherical)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:    state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (bit_reg == 6'd0)
                begin
                    axis_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (root_reg == '0)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_ACC:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (SLOT_W+1)'(MAX_SOURCES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            idx_reg   <= '0;
            axis_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            axis_reg  <= axis_next;
            done_reg  <= (state_reg == ST_DONE);
            if (accept && (op_t'(operation) == OP_WRITE
                           || op_t'(operation) == OP_REMOVE))
            begin
                valid_reg[slot[SLOT_W-1:0]] <= (op_t'(operation) == OP_WRITE);
            end
        end
    end

    // datapath
    logic signed [37:0] clip_in [3];
    logic signed [31:0] clip_out [3];
    logic [2:0]         clip_hit;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clip_in[i] = acc_reg[i];
            if (clip_in[i] > 38'sd2147483647)
            begin
                clip_out[i] = 32'sh7fffffff;
                clip_hit[i] = 1'b1;
            end
            else if (clip_in[i] < -38'sd2147483648)
            begin
                clip_out[i] = 32'sh80000000;
                clip_hit[i] = 1'b1;
            end
            else
            begin
                clip_out[i] = clip_in[i][31:0];
                clip_hit[i] = 1'b0;
            end
        end
    end

    logic signed [37:0] term;
    assign term = neg_term ? -38'(signed'({1'b0, div_q[36:0]}))
                           : 38'(signed'({1'b0, div_q[36:0]}));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= vec_x;
            py_reg <= vec_y;
            pz_reg <= vec_z;
            qmask_reg <= select_mask[MASK_BITS-1:0];
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        unique case (state_reg)
            ST_CHECK:
            begin
                d_reg[0] <= 33'(ent.vx) - 33'(px_reg);
                d_reg[1] <= 33'(ent.vy) - 33'(py_reg);
                d_reg[2] <= 33'(ent.vz) - 33'(pz_reg);
                if (valid_reg[raddr] && (ent.mask & qmask_reg) != '0
                    && ent.strength != '0 && !ent.spherical)
                begin
                    acc_reg[0] <= acc_reg[0] + 38'(ent.vx);
                    acc_reg[1] <= acc_reg[1] + 38'(ent.vy);
                    acc_reg[2] <= acc_reg[2] + 38'(ent.vz);
                end
            end
            ST_SQ:
            begin
                sq_reg   <= ({33'd0, mag_d[0]} * {33'd0, mag_d[0]})
                          + ({33'd0, mag_d[1]} * {33'd0, mag_d[1]})
                          + ({33'd0, mag_d[2]} * {33'd0, mag_d[2]});
                root_reg <= '0;
                bit_reg  <= 6'd33;
            end
            ST_SQRT:
            begin
                if (trial_sq <= {2'b00, sq_reg})
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - 6'd1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    acc_reg[axis_reg] <= acc_reg[axis_reg] + term;
                end
            end
            ST_DONE:
            begin
                fx_reg  <= clip_out[0];
                fy_reg  <= clip_out[1];
                fz_reg  <= clip_out[2];
                sat_reg <= |clip_hit;
            end
            default: ;
        endcase
    end

    assign done      = done_reg;
    assign force_x   = fx_reg;
    assign force_y   = fy_reg;
    assign force_z   = fz_reg;
    assign saturated = sat_reg;

endmodule

### hw/rtl/gfs_checker.sv
// ----------------------------------------------------------------------------
// gfs_checker
// Port-level checks on the command and result sides.
// ----------------------------------------------------------------------------
module gfs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic [1:0] operation,
    input logic done,
    input logic saturated,
    input logic signed [31:0] force_x
);
    import gfs_pkg::*;

    // a query beat always makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_QUERY |=> busy)
        else $error("query not taken");

    // write and remove finish at once
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_WRITE || operation == OP_REMOVE) |=> !busy)
        else $error("write held busy");

    // result strobe comes right as busy falls
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("done without end of query");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("double done");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({force_x, saturated}))
        else $error("unknown result");

endmodule

bind gravity_field_force_sum gfs_checker u_gfs_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .operation(operation), .done(done), .saturated(saturated), .force_x(force_x)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives table writes, removes and force queries into the gravity field force
// sum block and checks every query result against a local Q16.16 predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import gfs_pkg::*;

    typedef struct {
        op_t                 op;
        logic [3:0]          slot;
        logic signed [31:0]  vx;
        logic signed [31:0]  vy;
        logic signed [31:0]  vz;
        logic signed [31:0]  strength;
        logic                spherical;
        logic [15:0]         mask;
    } cmd_t;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               sat;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] operation = '0;
    logic [3:0] slot = '0;
    logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0, strength = '0;
    logic spherical = 1'b0;
    logic [15:0] select_mask = '0;
    logic done;
    logic signed [31:0] force_x, force_y, force_z;
    logic saturated;

    cmd_t   cmd_q[$];
    force_t force_q[$];
    int     errors = 0;
    int     queries = 0;
    int     results = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    bit     stim_done = 1'b0;

    // shadow source table
    logic signed [31:0] tab_x[16], tab_y[16], tab_z[16], tab_s[16];
    logic               tab_sph[16];
    logic [15:0]        tab_mask[16];
    logic               tab_valid[16];

    // placement of a few source centers used by the queries
    logic signed [31:0] hot_x[4], hot_y[4], hot_z[4];

    gravity_field_force_sum i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .slot(slot), .vec_x(vec_x), .vec_y(vec_y),
        .vec_z(vec_z), .strength(strength), .spherical(spherical),
        .select_mask(select_mask), .done(done), .force_x(force_x),
        .force_y(force_y), .force_z(force_z), .saturated(saturated)
    );

    always #1 clk = ~clk;

    function automatic logic [65:0] int_sqrt(input logic [67:0] n);
        logic [65:0] r;
        logic [65:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (66'd1 << b);
            if ({2'b0, t} * {2'b0, t} <= {64'b0, n}) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [39:0] clip(input logic signed [39:0] v,
                                               inout logic sat);
        if (v > 40'sd2147483647) begin
            sat = 1'b1;
            return 40'sd2147483647;
        end
        if (v < -40'sd2147483648) begin
            sat = 1'b1;
            return -40'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [39:0] pull(input logic signed [32:0] s,
                                               input logic signed [32:0] d,
                                               input logic [65:0] len);
        logic [65:0] ms, md, q;
        ms = s < 0 ? -s : s;
        md = d < 0 ? -d : d;
        q = (ms * md) / len;
        return ((s < 0) != (d < 0)) ? -$signed({1'b0, q[38:0]}) : $signed({1'b0, q[38:0]});
    endfunction

    // apply one command to the shadow table; returns 1 with a force for queries
    function automatic bit apply_cmd(input cmd_t c, output force_t f);
        logic signed [39:0] ax, ay, az;
        logic signed [32:0] dx, dy, dz;
        logic [67:0] sq;
        logic [65:0] len;
        logic sat;
        f = '{default: '0};
        if (c.op == OP_WRITE) begin
            tab_x[c.slot] = c.vx;
            tab_y[c.slot] = c.vy;
            tab_z[c.slot] = c.vz;
            tab_s[c.slot] = c.strength;
            tab_sph[c.slot] = c.spherical;
            tab_mask[c.slot] = c.mask;
            tab_valid[c.slot] = 1'b1;
            return 1'b0;
        end
        if (c.op == OP_REMOVE) begin
            tab_valid[c.slot] = 1'b0;
            return 1'b0;
        end
        if (c.op != OP_QUERY) return 1'b0;
        ax = '0;
        ay = '0;
        az = '0;
        sat = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (!tab_valid[i] || (tab_mask[i] & c.mask) == 0 || tab_s[i] == 0) continue;
            if (tab_sph[i]) begin
                dx = 33'(tab_x[i]) - 33'(c.vx);
                dy = 33'(tab_y[i]) - 33'(c.vy);
                dz = 33'(tab_z[i]) - 33'(c.vz);
                sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
                len = int_sqrt(sq);
                if (len == 0) continue;
                ax += pull(33'(tab_s[i]), dx, len);
                ay += pull(33'(tab_s[i]), dy, len);
                az += pull(33'(tab_s[i]), dz, len);
            end else begin
                ax += 40'(tab_x[i]);
                ay += 40'(tab_y[i]);
                az += 40'(tab_z[i]);
            end
        end
        ax = clip(ax, sat);
        ay = clip(ay, sat);
        az = clip(az, sat);
        f.fx = ax[31:0];
        f.fy = ay[31:0];
        f.fz = az[31:0];
        f.sat = sat;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 2047)) - 1024;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int k;
        k = $urandom_range(0, 99);
        c.slot = 4'($urandom());
        c.spherical = 1'($urandom());
        c.mask = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'(1 << $urandom_range(0, 3));
        c.strength = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_coord();
        c.vx = rand_coord();
        c.vy = rand_coord();
        c.vz = rand_coord();
        if (k < 30) c.op = OP_WRITE;
        else if (k < 40) c.op = OP_REMOVE;
        else if (k < 43) c.op = OP_NONE;
        else begin
            c.op = OP_QUERY;
            // sometimes sit exactly on a known center
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, 3);
                c.vx = hot_x[k];
                c.vy = hot_y[k];
                c.vz = hot_z[k];
            end
        end
        if (c.op == OP_WRITE && c.slot < 4 && c.spherical) begin
            hot_x[c.slot] = c.vx;
            hot_y[c.slot] = c.vy;
            hot_z[c.slot] = c.vz;
        end
        return c;
    endfunction

    function automatic cmd_t mk(input op_t op, input int sl, input int x, input int y,
                                input int z, input int s, input bit sph,
                                input int m);
        cmd_t c;
        c.op = op;
        c.slot = 4'(sl);
        c.vx = x;
        c.vy = y;
        c.vz = z;
        c.strength = s;
        c.spherical = sph;
        c.mask = 16'(m);
        return c;
    endfunction

    initial begin
        for (int i = 0; i < 16; i++) tab_valid[i] = 1'b0;
        for (int i = 0; i < 4; i++) begin
            hot_x[i] = 0;
            hot_y[i] = 0;
            hot_z[i] = 0;
        end
        // directed: empty table, planar 9.8 down, point source, zero distance,
        // zero strength, mask miss, saturation, remove, unused op
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        cmd_q.push_back(mk(OP_WRITE, 0, 0, -642252, 0, 65536, 0, 16'h0001));
        cmd_q.push_back(mk(OP_QUERY, 0, 5, 5, 5, 0, 0, 16'h0001));
        cmd_q.push_back(mk(OP_WRITE, 1, 65536, 0, 0, 131072, 1, 16'h0002));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 16'h0003));
        cmd_q.push_back(mk(OP_QUERY, 0, 65536, 0, 0, 0, 0, 16'h0002));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 16'h8000));
        cmd_q.push_back(mk(OP_WRITE, 2, 1, 1, 1, 0, 0, 16'hFFFF));
        cmd_q.push_back(mk(OP_WRITE, 3, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 0, 16'h8000));
        cmd_q.push_back(mk(OP_WRITE, 4, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 0, 16'hC000));
        cmd_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        cmd_q.push_back(mk(OP_WRITE, 5, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 1, 16'h4000));
        cmd_q.push_back(mk(OP_QUERY, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           0, 1, 16'h4000));
        cmd_q.push_back(mk(OP_NONE, 6, 1, 2, 3, 4, 1, 16'hFFFF));
        cmd_q.push_back(mk(OP_REMOVE, 3, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_REMOVE, 15, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(OP_QUERY, 0, -1, -1, -1, -1, 1, 16'hFFFF));
        for (int i = 0; i < 1000; i++) cmd_q.push_back(rand_cmd());
    end

    // driver: bursts with random gaps
    always @(posedge clk) begin
        cmd_t c;
        force_t f;
        if (rst_n) begin
            if (start && !busy) begin
                if (apply_cmd(cmd_q[0], f)) begin
                    force_q.push_back(f);
                    queries++;
                end
                void'(cmd_q.pop_front());
            end
            if (start && busy) begin
                // hold the current beat
            end else if (cmd_q.size() > 0 && gap_left == 0) begin
                c = cmd_q[0];
                start <= 1'b1;
                operation <= c.op;
                slot <= c.slot;
                vec_x <= c.vx;
                vec_y <= c.vy;
                vec_z <= c.vz;
                strength <= c.strength;
                spherical <= c.spherical;
                select_mask <= c.mask;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
                if (gap_left > 0) gap_left--;
                if (cmd_q.size() == 0) stim_done = 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        force_t e;
        if (rst_n && done) begin
            results++;
            if (force_q.size() == 0) begin
                $error("result with no query pending");
                errors++;
            end else begin
                e = force_q.pop_front();
                if (force_x !== e.fx) begin
                    $error("force_x expected %0d actual %0d", e.fx, force_x);
                    errors++;
                end
                if (force_y !== e.fy) begin
                    $error("force_y expected %0d actual %0d", e.fy, force_y);
                    errors++;
                end
                if (force_z !== e.fz) begin
                    $error("force_z expected %0d actual %0d", e.fz, force_z);
                    errors++;
                end
                if (saturated !== e.sat) begin
                    $error("saturated expected %0d actual %0d", e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && !start && force_q.size() == 0);
        repeat (50) @(posedge clk);
        if (force_q.size() != 0) errors++;
        $display("ran %0d commands, %0d queries checked against %0d results",
                 1017, queries, results);
        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    // worst case is roughly 600 queries, each walking all 16 slots
    initial begin
        #30000000;
        $display("tb_top failed");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/gfs_pkg.sv
hw/rtl/gfs_table.sv
hw/rtl/gfs_divider.sv
hw/rtl/gravity_field_force_sum.sv
hw/rtl/gfs_checker.sv
sim/tb_top.sv
